### src/blrs_pkg.sv
package blrs_pkg;

  localparam int unsigned LineLen  = 64;
  localparam int unsigned FracBits = 8;
  localparam int unsigned SegW     = $clog2(LineLen);
  localparam int unsigned PosW     = $clog2(LineLen << FracBits) + 1;
  localparam int unsigned SfW      = 12;
  localparam int unsigned RunW     = 7;
  localparam int unsigned LenW     = SfW + RunW + 1;

  localparam logic [PosW-1:0] PosLimit = PosW'(LineLen << FracBits);
  localparam logic [PosW-1:0] PosHalf  = PosW'(1 << (FracBits - 1));
  localparam logic [PosW-1:0] FillMax  = PosW'((LineLen - 1) << FracBits);
  localparam logic [SegW-1:0] SegLast  = SegW'(LineLen - 1);
  localparam logic [RunW-1:0] RunMax   = '1;
  localparam logic [SfW-1:0]  ScaleRst = SfW'(1 << FracBits);

  typedef struct packed {
    logic pixel_in;
    logic line_end_in;
  } pix_word_t;

  typedef struct packed {
    logic [SegW-1:0] seg_start;
    logic [SegW-1:0] seg_end;
    logic            seg_value;
    logic            last_of_item;
    logic            line_done;
  } seg_word_t;

endpackage

### src/bitmap_line_run_scaler_top.sv
// A segment word is written into the result queue when the pixel word causing it is
// accepted. Throughput: one pixel word per cycle while each pixel causes at most one
// segment and the output is not stalled; a pixel causing two or three segments stalls
// the input while the single output port drains the queue one a cycle when not stalled.
// Reset: scale returns to one (256), the open run and output position clear, the queue
// empties.
module bitmap_line_run_scaler_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [blrs_pkg::SfW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  blrs_pkg::pix_word_t        in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output blrs_pkg::seg_word_t        out_word_o
);

  typedef struct packed {
    logic                        emit;
    logic [blrs_pkg::SegW-1:0]   start;
    logic [blrs_pkg::SegW-1:0]   stop;
    logic [blrs_pkg::PosW-1:0]   pos;
  } close_t;

  function automatic close_t close_run(input logic [blrs_pkg::PosW-1:0] pos,
                                       input logic [blrs_pkg::LenW-1:0] len);
    logic [blrs_pkg::LenW-1:0] sum;
    logic [blrs_pkg::PosW-1:0] endpos;
    logic [blrs_pkg::PosW-1:0] s_fix;
    logic [blrs_pkg::PosW-1:0] e_fix;
    logic [blrs_pkg::PosW-1:0] s_int;
    logic [blrs_pkg::PosW-1:0] e_int;
    close_t r;
    sum    = blrs_pkg::LenW'(pos) + len;
    endpos = (sum >= blrs_pkg::LenW'(blrs_pkg::PosLimit)) ? blrs_pkg::PosLimit
                                                          : sum[blrs_pkg::PosW-1:0];
    s_fix  = pos + blrs_pkg::PosHalf;
    e_fix  = (endpos < blrs_pkg::PosHalf) ? '0 : endpos - blrs_pkg::PosHalf;
    s_int  = s_fix >> blrs_pkg::FracBits;
    e_int  = e_fix >> blrs_pkg::FracBits;
    r.emit  = (e_int >= s_int);
    r.start = s_int[blrs_pkg::SegW-1:0];
    r.stop  = e_int[blrs_pkg::SegW-1:0];
    r.pos   = endpos;
    return r;
  endfunction

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  logic [blrs_pkg::SfW-1:0]  scale_q;
  logic                      run_value_q, run_value_d;
  logic [blrs_pkg::RunW-1:0] run_count_q, run_count_d;
  logic [blrs_pkg::PosW-1:0] pos_q, pos_d;

  blrs_pkg::seg_word_t       queue_q [QDepth];
  logic [QPtrW-1:0]          wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]            count_q, count_d;

  logic                      accept, pop, changed;
  logic [blrs_pkg::RunW-1:0] run_next, mul_count;
  logic [blrs_pkg::LenW-1:0] product, len2;
  logic [blrs_pkg::PosW-1:0] pos1;
  close_t                    c1, c2;
  logic                      fill_due;
  blrs_pkg::seg_word_t       cand [3];
  logic [2:0]                cand_v;
  blrs_pkg::seg_word_t       res [3];
  logic [1:0]                push_n;

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  assign in_stall_o  = (count_q > (QPtrW+1)'(1));
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = queue_q[rd_ptr_q];

  always_comb begin
    changed   = (run_count_q != '0) && (in_word_i.pixel_in != run_value_q);
    if (changed || run_count_q == '0) begin
      run_next = blrs_pkg::RunW'(1);
    end else if (run_count_q < blrs_pkg::RunMax) begin
      run_next = run_count_q + blrs_pkg::RunW'(1);
    end else begin
      run_next = run_count_q;
    end
    mul_count = changed ? run_count_q : run_next;
    product   = blrs_pkg::LenW'(scale_q) * blrs_pkg::LenW'(mul_count);
    c1        = close_run(pos_q, product);
    pos1      = changed ? c1.pos : pos_q;
    len2      = changed ? blrs_pkg::LenW'(scale_q) : product;
    c2        = close_run(pos1, len2);
    fill_due  = (c2.pos < blrs_pkg::FillMax);

    cand_v[0] = changed && c1.emit;
    cand_v[1] = in_word_i.line_end_in && c2.emit;
    cand_v[2] = in_word_i.line_end_in && fill_due;

    cand[0].seg_start    = c1.start;
    cand[0].seg_end      = c1.stop;
    cand[0].seg_value    = run_value_q;
    cand[0].last_of_item = !(cand_v[1] || cand_v[2]);
    cand[0].line_done    = in_word_i.line_end_in && !(cand_v[1] || cand_v[2]);

    cand[1].seg_start    = c2.start;
    cand[1].seg_end      = c2.stop;
    cand[1].seg_value    = changed ? in_word_i.pixel_in
                                   : (run_count_q == '0 ? in_word_i.pixel_in : run_value_q);
    cand[1].last_of_item = !cand_v[2];
    cand[1].line_done    = !cand_v[2];

    cand[2].seg_start    = c2.pos[blrs_pkg::FracBits +: blrs_pkg::SegW];
    cand[2].seg_end      = blrs_pkg::SegLast;
    cand[2].seg_value    = 1'b0;
    cand[2].last_of_item = 1'b1;
    cand[2].line_done    = 1'b1;

    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    push_n = '0;
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        res[push_n] = cand[i];
        push_n      = push_n + 2'd1;
      end
    end
    if (!accept) begin
      push_n = '0;
    end

    if (in_word_i.line_end_in) begin
      run_value_d = 1'b0;
      run_count_d = '0;
      pos_d       = '0;
    end else begin
      run_value_d = (changed || run_count_q == '0) ? in_word_i.pixel_in : run_value_q;
      run_count_d = run_next;
      pos_d       = pos1;
    end

    count_d = count_q + (QPtrW+1)'(push_n) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= blrs_pkg::ScaleRst;
      run_value_q <= 1'b0;
      run_count_q <= '0;
      pos_q       <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
      if (accept) begin
        run_value_q <= run_value_d;
        run_count_q <= run_count_d;
        pos_q       <= pos_d;
      end
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < push_n) begin
        queue_q[wr_ptr_q + QPtrW'(j)] <= res[j];
      end
    end
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW+1)'(QDepth))
    else $error("result queue overflow");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= blrs_pkg::PosLimit)
    else $error("output position beyond line length");

  a_line_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_word_i.line_end_in |=> (run_count_q == '0) && (pos_q == '0))
    else $error("run state not cleared after line end");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.line_done |-> out_word_o.last_of_item)
    else $error("line end word not marked last of its pixel");

endmodule

### tb/sv/bitmap_line_run_scaler_checker.sv
`timescale 1ns / 100ps

module bitmap_line_run_scaler_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [blrs_pkg::SfW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  blrs_pkg::pix_word_t      in_word_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  blrs_pkg::seg_word_t      out_word_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  import blrs_pkg::*;

  localparam int unsigned LimitPos = LineLen << FracBits;
  localparam int unsigned HalfPx   = 1 << (FracBits - 1);
  localparam int unsigned FillTop  = (LineLen - 1) << FracBits;

  logic [SfW-1:0]  scale_q;
  logic            run_px;
  logic [RunW-1:0] run_len;
  int unsigned     line_pos;
  seg_word_t       step_segs [3];
  int unsigned     step_n;
  seg_word_t       seg_expect_q [$];

  task automatic close_run();
    int unsigned seg_len;
    int unsigned end_pos;
    int unsigned first_px;
    int unsigned last_px;
    int unsigned scale_v;
    int unsigned run_v;
    scale_v = scale_q;
    run_v   = run_len;
    seg_len = scale_v * run_v;
    if (line_pos + seg_len >= LimitPos) begin
      seg_len = (line_pos <= LimitPos) ? LimitPos - line_pos : 0;
    end
    end_pos  = line_pos + seg_len;
    first_px = (line_pos + HalfPx) >> FracBits;
    last_px  = (end_pos < HalfPx) ? 0 : (end_pos - HalfPx) >> FracBits;
    line_pos = end_pos;
    run_len  = '0;
    if (last_px >= first_px) begin
      step_segs[step_n] = {SegW'(first_px), SegW'(last_px), run_px, 1'b0, 1'b0};
      step_n++;
    end
  endtask

  task automatic predict_pixel(input pix_word_t word);
    step_n = 0;
    if (run_len != 0 && word.pixel_in != run_px) begin
      close_run();
    end
    if (run_len == 0) begin
      run_px  = word.pixel_in;
      run_len = RunW'(1);
    end else if (run_len != RunMax) begin
      run_len++;
    end
    if (word.line_end_in) begin
      close_run();
      // The rest of the line is cleared unless the position already sits on the last pixel.
      if (line_pos < FillTop) begin
        step_segs[step_n] = {SegW'(line_pos >> FracBits), SegLast, 1'b0, 1'b0, 1'b0};
        step_n++;
      end
      if (step_n > 0) begin
        step_segs[step_n-1].line_done = 1'b1;
      end
      run_px   = 1'b0;
      run_len  = '0;
      line_pos = 0;
    end
    if (step_n > 0) begin
      step_segs[step_n-1].last_of_item = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      seg_expect_q.push_back(step_segs[i]);
    end
  endtask

  task automatic check_field(input string field, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $error("%s: expected %0d, actual %0d", field, expected, actual);
      fail_count_o++;
    end
  endtask

  task automatic check_segment(input seg_word_t word);
    seg_word_t want;
    if (seg_expect_q.size() == 0) begin
      $error("unexpected segment word: start %0d end %0d value %0d",
             word.seg_start, word.seg_end, word.seg_value);
      fail_count_o++;
    end else begin
      want = seg_expect_q.pop_front();
      check_field("seg_start", want.seg_start, word.seg_start);
      check_field("seg_end", want.seg_end, word.seg_end);
      check_field("seg_value", want.seg_value, word.seg_value);
      check_field("last_of_item", want.last_of_item, word.last_of_item);
      check_field("line_done", want.line_done, word.line_done);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      = ScaleRst;
      run_px       = 1'b0;
      run_len      = '0;
      line_pos     = 0;
      fail_count_o = 0;
      pending_o    = 0;
      seg_expect_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_segment(out_word_i);
      end
      if (in_valid_i && !in_stall_i) begin
        predict_pixel(in_word_i);
      end
      if (cfg_we_i) begin
        scale_q = cfg_data_i;
      end
      pending_o = seg_expect_q.size();
    end
  end

endmodule

### tb/sv/tb_bitmap_line_run_scaler_top.sv
`timescale 1ns / 100ps

module tb_bitmap_line_run_scaler_top;

  import blrs_pkg::*;

  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned RandomPixels = 300;

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  logic [SfW-1:0] cfg_data;
  logic           pix_valid;
  logic           pix_stall;
  pix_word_t      pix_word;
  logic           seg_valid;
  logic           seg_stall;
  seg_word_t      seg_word;
  int unsigned    seg_fails;
  int unsigned    seg_pending;
  bit             idle_enable;
  int unsigned    pixels_sent;

  bitmap_line_run_scaler_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_valid_i (pix_valid),
    .in_stall_o (pix_stall),
    .in_word_i  (pix_word),
    .out_valid_o(seg_valid),
    .out_stall_i(seg_stall),
    .out_word_o (seg_word)
  );

  bitmap_line_run_scaler_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (pix_valid),
    .in_stall_i  (pix_stall),
    .in_word_i   (pix_word),
    .out_valid_i (seg_valid),
    .out_stall_i (seg_stall),
    .out_word_i  (seg_word),
    .fail_count_o(seg_fails),
    .pending_o   (seg_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    seg_stall = 1'b0;
    forever begin
      @(negedge clk);
      seg_stall <= idle_enable && ($urandom_range(99) < 34);
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk);
      if (!rst_n || (pix_valid && !pix_stall) || (seg_valid && !seg_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("tb_bitmap_line_run_scaler_top: FAIL");
    $finish;
  end

  task automatic send_pixel(input logic pixel, input logic line_end);
    while (idle_enable && $urandom_range(99) < 34) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_word  <= '{pixel_in: pixel, line_end_in: line_end};
    do @(posedge clk); while (pix_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_bits(input logic [31:0] bits, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(bits[i], i == count - 1);
    end
  endtask

  task automatic send_line(input int unsigned count, input int unsigned flip_pct);
    logic pixel;
    pixel = 1'($urandom_range(1));
    for (int unsigned i = 0; i < count; i++) begin
      if (i > 0 && $urandom_range(99) < flip_pct) begin
        pixel = ~pixel;
      end
      send_pixel(pixel, i == count - 1);
    end
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    while (seg_pending != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SfW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [SfW-1:0] pick_scale();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return ScaleRst;
      3:       return SfW'(128);
      4:       return SfW'($urandom_range(1, 64));
      5:       return SfW'($urandom_range(200, 600));
      default: return SfW'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    int unsigned line_no;
    int unsigned pixel_goal;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    pix_valid   = 1'b0;
    pix_word    = '0;
    idle_enable = 1'b1;
    pixels_sent = 0;
    rst_n       = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_bits(32'b101, 3);
    drain();
    write_scale('1);
    // A full run pushes the position to the line end, so the closing run is empty.
    send_bits(32'b0011111, 7);
    drain();
    write_scale('0);
    send_bits(32'b010, 3);
    drain();
    write_scale(SfW'(128));
    send_bits(32'b1, 1);
    drain();
    write_scale(SfW'(257));
    send_bits(32'b0110, 4);

    line_no    = 0;
    pixel_goal = pixels_sent + RandomPixels;
    while (pixels_sent < pixel_goal) begin
      line_no++;
      idle_enable = !(line_no >= 8 && line_no < 14);
      if (line_no == 4) begin
        drain();
        write_scale(SfW'($urandom_range(1, 120)));
        send_line(130, 0);
      end else begin
        if (line_no % 3 == 0) begin
          drain();
          write_scale(pick_scale());
        end
        case ($urandom_range(9))
          0:       send_line($urandom_range(1, 64), 0);
          1:       send_line(LineLen, $urandom_range(0, 20));
          default: send_line($urandom_range(1, 24), $urandom_range(10, 60));
        endcase
      end
    end

    idle_enable = 1'b1;
    drain();
    repeat (10) @(negedge clk);
    if (seg_fails == 0) begin
      $display("tb_bitmap_line_run_scaler_top: PASS");
    end else begin
      $display("tb_bitmap_line_run_scaler_top: FAIL");
    end
    $finish;
  end

endmodule
